// ===== hw/rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int OP_W         = 2;
  localparam int KEY_W        = 32;
  localparam int PL_W         = 32;
  localparam int ST_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_CHECK,
    S_ACT,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic step;
    logic rd_lo;
    logic check;
    logic shift_init;
    logic shift;
    logic finish;
    logic resp;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic shift_busy;
  } stat_t;

endpackage

// ===== hw/rtl/skt_if.sv =====
// ----------------------------------------------------------------------------
// Sorted key table channels
// Valid/ready channels for requests and for responses.
// ----------------------------------------------------------------------------
interface skt_in_if;
  logic                     valid;
  logic                     ready;
  logic [skt_pkg::OP_W-1:0]  op;
  logic [skt_pkg::KEY_W-1:0] key;
  logic [skt_pkg::PL_W-1:0]  payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skt_out_if #(
  parameter int CNT_W = 7
);
  logic                     valid;
  logic                     ready;
  logic [skt_pkg::ST_W-1:0] status;
  logic [CNT_W-1:0]         position;
  logic [skt_pkg::PL_W-1:0] found_payload;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output status, output position, output found_payload,
                  output count, input ready);
  modport sink   (input valid, input status, input position, input found_payload,
                  input count, output ready);
endinterface

// ===== hw/rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences the binary search, the entry shift and the response hand-off.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  skt_pkg::stat_t stat,
  output skt_pkg::cmd_t  cmd
);

  skt_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      skt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = skt_pkg::S_SEARCH;
        end
      end
      skt_pkg::S_SEARCH: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_nxt  = skt_pkg::S_COMPARE;
        end else begin
          cmd.rd_lo = 1'b1;
          state_nxt = skt_pkg::S_CHECK;
        end
      end
      skt_pkg::S_COMPARE: begin
        cmd.step  = 1'b1;
        state_nxt = skt_pkg::S_SEARCH;
      end
      skt_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = skt_pkg::S_ACT;
      end
      skt_pkg::S_ACT: begin
        state_nxt = skt_pkg::S_RESP;
        case (stat.op)
          skt_pkg::OP_INSERT: begin
            if (!stat.hit && !stat.full) begin
              cmd.shift_init = 1'b1;
              state_nxt      = skt_pkg::S_SHIFT;
            end
          end
          skt_pkg::OP_LOOKUP: begin
            cmd.rd_lo = stat.hit;
          end
          skt_pkg::OP_UPDATE: begin
            if (stat.hit) begin
              state_nxt = skt_pkg::S_FINISH;
            end
          end
          default: begin
            if (stat.hit) begin
              cmd.shift_init = 1'b1;
              state_nxt      = skt_pkg::S_SHIFT;
            end
          end
        endcase
      end
      skt_pkg::S_SHIFT: begin
        if (stat.shift_busy) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = skt_pkg::S_RESP;
      end
      skt_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/skt_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Key and payload memories, search bounds, shift pointers, entry count and
// the response register.
// ----------------------------------------------------------------------------
module skt_dp #(
  parameter int DEPTH    = skt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [skt_pkg::OP_W-1:0]   in_op,
  input  logic [skt_pkg::KEY_W-1:0]  in_key,
  input  logic [skt_pkg::PL_W-1:0]   in_payload,
  input  skt_pkg::cmd_t              cmd,
  output skt_pkg::stat_t             stat,
  output logic [skt_pkg::ST_W-1:0]   out_status,
  output logic [$clog2(DEPTH+1)-1:0] out_position,
  output logic [skt_pkg::PL_W-1:0]   out_found_payload,
  output logic [$clog2(DEPTH+1)-1:0] out_count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int KW    = (KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W;

  logic [KW-1:0]           key_mem [DEPTH];
  logic [skt_pkg::PL_W-1:0] pl_mem [DEPTH];

  skt_pkg::op_t            op_r;
  logic [KW-1:0]           key_r;
  logic [skt_pkg::PL_W-1:0] pl_r;
  logic [CNT_W-1:0]        lo_r, hi_r, cnt_r, rem_r;
  logic [AW-1:0]           mid_r, src_r, dest_r;
  logic                    hit_r, full_r, pend_r;
  logic [KW-1:0]           key_q;
  logic [skt_pkg::PL_W-1:0] pl_q;
  skt_pkg::status_t        status_r;
  logic [CNT_W-1:0]        position_r, count_r;
  logic [skt_pkg::PL_W-1:0] fpay_r;

  logic [CNT_W-1:0]        mid;
  logic                    is_ins;
  logic                    re;
  logic [AW-1:0]           raddr;
  logic                    wk_en, wp_en;
  logic [AW-1:0]           waddr;
  logic [KW-1:0]           wkey;
  logic [skt_pkg::PL_W-1:0] wpl;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign is_ins = (op_r == skt_pkg::OP_INSERT);

  always_comb begin
    re    = cmd.rd_mid | cmd.rd_lo | (cmd.shift & (rem_r != '0));
    raddr = lo_r[AW-1:0];
    if (cmd.rd_mid) begin
      raddr = mid[AW-1:0];
    end else if (cmd.shift) begin
      raddr = src_r;
    end
  end

  always_comb begin
    wk_en = 1'b0;
    wp_en = 1'b0;
    waddr = lo_r[AW-1:0];
    wkey  = key_r;
    wpl   = pl_r;
    if (cmd.shift && pend_r) begin
      wk_en = 1'b1;
      wp_en = 1'b1;
      waddr = dest_r;
      wkey  = key_q;
      wpl   = pl_q;
    end else if (cmd.finish) begin
      wk_en = is_ins;
      wp_en = is_ins | (op_r == skt_pkg::OP_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (wk_en) begin
      key_mem[waddr] <= wkey;
    end
    if (wp_en) begin
      pl_mem[waddr] <= wpl;
    end
    if (re) begin
      key_q <= key_mem[raddr];
      pl_q  <= pl_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      if (cmd.shift_init) begin
        rem_r <= is_ins ? (cnt_r - lo_r) : (cnt_r - lo_r - CNT_W'(1));
      end else if (cmd.shift) begin
        if (rem_r != '0) begin
          rem_r  <= rem_r - CNT_W'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.finish) begin
        if (is_ins) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else if (op_r == skt_pkg::OP_DELETE) begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= skt_pkg::op_t'(in_op);
      key_r <= in_key[KW-1:0];
      pl_r  <= in_payload;
      lo_r  <= '0;
      hi_r  <= cnt_r;
    end
    if (cmd.rd_mid) begin
      mid_r <= mid[AW-1:0];
    end
    if (cmd.step) begin
      if (key_q < key_r) begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_r <= CNT_W'(mid_r);
      end
    end
    if (cmd.check) begin
      hit_r  <= (lo_r < cnt_r) && (key_q == key_r);
      full_r <= (cnt_r == CNT_W'(DEPTH));
    end
    if (cmd.shift_init) begin
      src_r <= is_ins ? AW'(cnt_r - CNT_W'(1)) : AW'(lo_r + CNT_W'(1));
    end else if (cmd.shift && (rem_r != '0)) begin
      dest_r <= is_ins ? (src_r + AW'(1)) : (src_r - AW'(1));
      src_r  <= is_ins ? (src_r - AW'(1)) : (src_r + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      count_r    <= cnt_r;
      fpay_r     <= '0;
      position_r <= lo_r;
      if (is_ins) begin
        if (hit_r) begin
          status_r <= skt_pkg::ST_DUPLICATE;
        end else if (full_r) begin
          status_r   <= skt_pkg::ST_FULL;
          position_r <= '0;
        end else begin
          status_r <= skt_pkg::ST_OK;
        end
      end else if (hit_r) begin
        status_r <= skt_pkg::ST_OK;
        if (op_r == skt_pkg::OP_LOOKUP) begin
          fpay_r <= pl_q;
        end
      end else begin
        status_r   <= skt_pkg::ST_NOT_FOUND;
        position_r <= '0;
      end
    end
  end

  assign stat.op         = op_r;
  assign stat.lo_lt_hi   = (lo_r < hi_r);
  assign stat.hit        = hit_r;
  assign stat.full       = (cnt_r == CNT_W'(DEPTH));
  assign stat.shift_busy = (rem_r != '0) | pend_r;

  assign out_status        = status_r;
  assign out_position      = position_r;
  assign out_found_payload = fpay_r;
  assign out_count         = count_r;

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// Each request runs a binary search over the N entries held, with at most
// ceil(log2(N+1)) search steps, then a hit check; an insert or delete that moves S > 0
// entries then shifts them one at a time through the single read port, which is
// shared by the search and the shift. A new request is taken only once the
// response to the previous one has been registered.
// Synchronous active-low reset empties the table; stored entries are not cleared.
// ----------------------------------------------------------------------------
// Sorted key table
// Records kept in ascending key order with insert, lookup, update and delete.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH    = skt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH+1);

  skt_pkg::cmd_t  cmd;
  skt_pkg::stat_t stat;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skt_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_ch.op),
    .in_key            (in_ch.key),
    .in_payload        (in_ch.payload),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_ch.status),
    .out_position      (out_ch.position),
    .out_found_payload (out_ch.found_payload),
    .out_count         (out_ch.count)
  );

endmodule

// ===== hw/rtl/skt_chk.sv =====
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level properties of the responses, bound to the top level.
// ----------------------------------------------------------------------------
module skt_chk #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF,
  parameter int CNT_W = 7
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [skt_pkg::ST_W-1:0] out_status,
  input logic [CNT_W-1:0]         out_position,
  input logic [skt_pkg::PL_W-1:0] out_found_payload,
  input logic [CNT_W-1:0]         out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("response changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == skt_pkg::ST_NOT_FOUND || out_status == skt_pkg::ST_FULL)
    |-> out_position == '0)
    else $error("non-zero position on a refused request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == skt_pkg::ST_FULL |-> out_count == CNT_W'(DEPTH))
    else $error("full status with free entries");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_payload != '0 |-> out_status == skt_pkg::ST_OK)
    else $error("payload returned on a failed request");

endmodule

bind sorted_key_table skt_chk #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_skt_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_position      (out_ch.position),
  .out_found_payload (out_ch.found_payload),
  .out_count         (out_ch.count)
);

// ===== sim/skt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table checker
// Watches the request and response channels. Every accepted request is run
// through a local copy of the sorted table, and the expected response is
// queued. Each accepted response is compared field by field with the oldest
// queued one. The failure count goes back to the testbench top.
// ----------------------------------------------------------------------------
module skt_checker (
  input  logic clk,
  input  logic rst_n,
  skt_in_if    in_mon,
  skt_out_if   out_mon,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   peak_entries
);

  localparam int DEPTH = skt_pkg::DEPTH_DEF;
  localparam int CNT_W = 7;

  typedef struct packed {
    skt_pkg::status_t         status;
    logic [CNT_W-1:0]         position;
    logic [skt_pkg::PL_W-1:0] found_payload;
    logic [CNT_W-1:0]         count;
  } response_t;

  logic [skt_pkg::KEY_W-1:0] key_tab [DEPTH];
  logic [skt_pkg::PL_W-1:0]  pl_tab [DEPTH];
  int unsigned               n_entries;
  response_t                 expected_responses[$];

  // Applies one request to the local table and returns the response it earns.
  function automatic response_t apply_table_request(skt_pkg::op_t op,
                                                    logic [skt_pkg::KEY_W-1:0] k,
                                                    logic [skt_pkg::PL_W-1:0] pl);
    response_t   r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    bit          hit;
    r = '0;
    r.status = skt_pkg::ST_OK;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key_tab[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < n_entries) && (key_tab[lo] == k);
    case (op)
      skt_pkg::OP_INSERT: begin
        if (hit) begin
          r.status   = skt_pkg::ST_DUPLICATE;
          r.position = lo[CNT_W-1:0];
        end else if (n_entries >= DEPTH) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          for (i = n_entries; i > lo; i--) begin
            key_tab[i] = key_tab[i-1];
            pl_tab[i]  = pl_tab[i-1];
          end
          key_tab[lo] = k;
          pl_tab[lo]  = pl;
          n_entries++;
          r.position = lo[CNT_W-1:0];
        end
      end
      skt_pkg::OP_LOOKUP: begin
        if (hit) begin
          r.position      = lo[CNT_W-1:0];
          r.found_payload = pl_tab[lo];
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::OP_UPDATE: begin
        if (hit) begin
          r.position = lo[CNT_W-1:0];
          pl_tab[lo] = pl;
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          for (i = lo; i + 1 < n_entries; i++) begin
            key_tab[i] = key_tab[i+1];
            pl_tab[i]  = pl_tab[i+1];
          end
          n_entries--;
          r.position = lo[CNT_W-1:0];
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
    endcase
    r.count = n_entries[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      n_entries = 0;
      expected_responses.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_responses.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response with none expected: status %0d position %0d count %0d",
                     $realtime, out_mon.status, out_mon.position, out_mon.count);
        end else begin
          want = expected_responses.pop_front();
          checked++;
          if (out_mon.status !== want.status || out_mon.position !== want.position ||
              out_mon.found_payload !== want.found_payload ||
              out_mon.count !== want.count) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: response mismatch: status %0d/%0d position %0d/%0d ",
                        "payload %h/%h count %0d/%0d (expected/actual)"},
                       $realtime, want.status, out_mon.status, want.position,
                       out_mon.position, want.found_payload, out_mon.found_payload,
                       want.count, out_mon.count);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_responses.push_back(apply_table_request(skt_pkg::op_t'(in_mon.op),
                                                         in_mon.key, in_mon.payload));
        if (n_entries > peak_entries) peak_entries = n_entries;
      end
    end
    pending = expected_responses.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives a directed run through the corner cases and then about five hundred
// random requests over four handshake phases, from no idling to heavy
// idling on either side. Keys come mostly from a small pool so that the
// table fills up, refuses new keys and hits present ones often.
// ----------------------------------------------------------------------------
module tb;

  localparam int POOL_SIZE = 72;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   n_sent;
  int   errors;
  int   pending;
  int   checked;
  int   peak_entries;

  logic [skt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  skt_in_if in_ch ();
  skt_out_if #(.CNT_W(7)) out_ch ();

  sorted_key_table #(
    .DEPTH    (64),
    .KEY_BITS (32)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  skt_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .peak_entries (peak_entries)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(input skt_pkg::op_t op, input logic [skt_pkg::KEY_W-1:0] k,
                              input logic [skt_pkg::PL_W-1:0] pl);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.key     <= k;
    in_ch.payload <= pl;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  function automatic skt_pkg::op_t pick_op(int insert_w, int delete_w);
    int r;
    r = $urandom_range(99);
    if (r < insert_w) return skt_pkg::OP_INSERT;
    if (r < insert_w + delete_w) return skt_pkg::OP_DELETE;
    return r[0] ? skt_pkg::OP_LOOKUP : skt_pkg::OP_UPDATE;
  endfunction

  initial begin
    int phase_len;
    int insert_w;
    int delete_w;
    logic [skt_pkg::KEY_W-1:0] k;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= skt_pkg::OP_INSERT;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    rst_n         <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Misses on an empty table, extremes of key and payload, duplicates,
    // first and last deletes and a repeated delete down to empty, then a fresh insert.
    send_request(skt_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'h0000_0005, 32'h0);
    send_request(skt_pkg::OP_UPDATE, 32'h0000_0007, 32'hFFFF_FFFF);
    send_request(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(skt_pkg::OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_request(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_request(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(skt_pkg::OP_LOOKUP, 32'h0001_2345, 32'h0);
    send_request(skt_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_UPDATE, 32'h0000_0001, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'h0000_0000, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'h8000_0000, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'h8000_0000, 32'h0);
    send_request(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_DELETE, 32'h7FFF_FFFF, 32'h0);
    send_request(skt_pkg::OP_INSERT, 32'h0000_0001, 32'hC3C3_C3C3);

    // The first phase is mostly inserts so that the table runs full.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  insert_w = 90; delete_w = 3;  end
        1: begin idle_pct = 85; stall_pct = 0;  insert_w = 25; delete_w = 25; end
        2: begin idle_pct = 0;  stall_pct = 85; insert_w = 15; delete_w = 55; end
        default: begin idle_pct = 13; stall_pct = 13; insert_w = 40; delete_w = 20; end
      endcase
      phase_len = (phase == 0) ? 160 : 115;
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(POOL_SIZE - 1)];
        send_request(pick_op(insert_w, delete_w), k, $urandom());
      end
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d requests over four idling phases; %0d responses checked.",
             n_sent, checked);
    $display("The table held at most %0d entries.", peak_entries);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run stopped: responses still outstanding.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sorted_key_table.f =====
hw/rtl/skt_pkg.sv
hw/rtl/skt_if.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_dp.sv
hw/rtl/sorted_key_table.sv
hw/rtl/skt_chk.sv
sim/skt_checker.sv
sim/tb.sv
